/* src/flight_phase_detector_macros.svh */
// Assertion helpers shared by the flight phase detector RTL.
`ifndef FLIGHT_PHASE_DETECTOR_MACROS_SVH
`define FLIGHT_PHASE_DETECTOR_MACROS_SVH

`ifndef SYNTHESIS
// Checked on every rising clock edge, ignored while reset is asserted.
`define FPD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Checked on every rising clock edge, reset included.
`define FPD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define FPD_ASSERT(lbl, prop, msg)
`define FPD_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

/* src/fpd_pkg.sv */
`default_nettype none

package fpd_pkg;

  localparam int unsigned AltW     = 24;
  localparam int unsigned AccW     = 24;
  localparam int unsigned JumpW    = 17;
  localparam int unsigned LimitW   = 8;
  localparam int unsigned GravW    = 16;
  localparam int unsigned BandW    = 14;
  localparam int unsigned CntW     = 9;
  localparam int unsigned CfgIdxW  = 8;
  localparam int unsigned CfgDataW = 17;

  // Wide enough for any sum or difference of altitude/accel and the thresholds.
  localparam int unsigned CmpW = 26;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CfgAltJump    = 8'd0;
  localparam logic [CfgIdxW-1:0] CfgSampLimit  = 8'd1;
  localparam logic [CfgIdxW-1:0] CfgGravity    = 8'd2;
  localparam logic [CfgIdxW-1:0] CfgAccelBand  = 8'd3;

  // Reset values of the configuration registers.
  localparam logic [JumpW-1:0]  AltJumpRst   = 17'd100;
  localparam logic [LimitW-1:0] SampLimitRst = 8'd10;
  localparam logic [GravW-1:0]  GravityRst   = 16'd9807;
  localparam logic [BandW-1:0]  AccelBandRst = 14'd1000;

  // Counter steps.
  localparam logic [CntW:0] JumpStep  = 10'd3;
  localparam logic [CntW:0] SmallStep = 10'd1;
  localparam logic [CntW-1:0] CntMax  = '1;

  typedef enum logic [1:0] {
    TREND_STATIONARY = 2'd0,
    TREND_RISING     = 2'd1,
    TREND_FALLING    = 2'd2
  } trend_e;

  typedef enum logic [2:0] {
    ACC_NEAR_ZERO = 3'd0,
    ACC_NEAR_G    = 3'd1,
    ACC_HIGH_POS  = 3'd2,
    ACC_LOW_NEG   = 3'd3,
    ACC_HIGH_NEG  = 3'd4
  } accel_class_e;

  typedef enum logic [3:0] {
    FS_STABILIZE      = 4'd0,
    FS_READY          = 4'd1,
    FS_BOOST          = 4'd2,
    FS_COAST          = 4'd3,
    FS_FALL           = 4'd4,
    FS_CHUTE_SLOWING  = 4'd5,
    FS_CHUTE_TERMINAL = 4'd6,
    FS_LANDED         = 4'd7,
    FS_UNKNOWN        = 4'd8
  } flight_state_e;

  typedef struct packed {
    logic [JumpW-1:0]  alt_jump_cm;
    logic [LimitW-1:0] trend_limit;
    logic [GravW-1:0]  gravity_mms2;
    logic [BandW-1:0]  accel_band_mms2;
  } cfg_t;

  function automatic flight_state_e decode_state(trend_e trend, accel_class_e acc,
                                                 logic chute, logic stab);
    flight_state_e st;
    st = FS_UNKNOWN;
    if (!chute && trend == TREND_STATIONARY && acc == ACC_NEAR_ZERO) begin
      st = stab ? FS_READY : FS_STABILIZE;
    end else if (!stab) begin
      st = FS_UNKNOWN;
    end else if (!chute) begin
      if (trend == TREND_RISING && acc == ACC_HIGH_POS) begin
        st = FS_BOOST;
      end else if (trend == TREND_RISING && (acc == ACC_NEAR_G || acc == ACC_LOW_NEG)) begin
        st = FS_COAST;
      end else if (trend == TREND_FALLING && acc == ACC_NEAR_G) begin
        st = FS_FALL;
      end
    end else begin
      if (trend == TREND_FALLING && acc == ACC_LOW_NEG) begin
        st = FS_CHUTE_SLOWING;
      end else if (trend == TREND_FALLING && acc == ACC_NEAR_ZERO) begin
        st = FS_CHUTE_TERMINAL;
      end else if (trend == TREND_STATIONARY && acc == ACC_NEAR_ZERO) begin
        st = FS_LANDED;
      end
    end
    return st;
  endfunction

endpackage

`default_nettype wire

/* src/fpd_in_if.sv */
`default_nettype none

interface fpd_in_if;
  import fpd_pkg::*;

  logic                   valid;
  logic                   ready;
  logic signed [AltW-1:0] altitude_cm;
  logic signed [AccW-1:0] vertical_accel;
  logic                   parachute_deployed;
  logic                   stable;

  modport source (output valid, altitude_cm, vertical_accel, parachute_deployed, stable,
                  input ready);
  modport sink   (input valid, altitude_cm, vertical_accel, parachute_deployed, stable,
                  output ready);
endinterface

`default_nettype wire

/* src/fpd_out_if.sv */
`default_nettype none

interface fpd_out_if;
  import fpd_pkg::*;

  logic       valid;
  logic       ready;
  logic [1:0] altitude_trend;
  logic [2:0] accel_class;
  logic [3:0] flight_state;

  modport source (output valid, altitude_trend, accel_class, flight_state, input ready);
  modport sink   (input valid, altitude_trend, accel_class, flight_state, output ready);
endinterface

`default_nettype wire

/* src/fpd_cfg_if.sv */
`default_nettype none

interface fpd_cfg_if;
  import fpd_pkg::*;

  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* src/fpd_cfg_regs.sv */
`default_nettype none

module fpd_cfg_regs (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  fpd_cfg_if.sink     cfg_i,
  output fpd_pkg::cfg_t cfg_o
);
  import fpd_pkg::*;

  cfg_t cfg_q, cfg_d;

  assign cfg_i.ready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      unique case (cfg_i.index)
        CfgAltJump:   cfg_d.alt_jump_cm     = cfg_i.data[JumpW-1:0];
        CfgSampLimit: cfg_d.trend_limit     = cfg_i.data[LimitW-1:0];
        CfgGravity:   cfg_d.gravity_mms2    = cfg_i.data[GravW-1:0];
        CfgAccelBand: cfg_d.accel_band_mms2 = cfg_i.data[BandW-1:0];
        default:      cfg_d = cfg_q; // unmapped index: ignored
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.alt_jump_cm     <= AltJumpRst;
      cfg_q.trend_limit     <= SampLimitRst;
      cfg_q.gravity_mms2    <= GravityRst;
      cfg_q.accel_band_mms2 <= AccelBandRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

/* src/fpd_trend.sv */
`default_nettype none

`include "flight_phase_detector_macros.svh"

module fpd_trend (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           step_i,
  input  wire logic signed [fpd_pkg::AltW-1:0] altitude_i,
  input  wire logic [fpd_pkg::JumpW-1:0]      alt_jump_i,
  input  wire logic [fpd_pkg::LimitW-1:0]     trend_limit_i,
  output fpd_pkg::trend_e                     trend_o
);
  import fpd_pkg::*;

  logic signed [AltW-1:0] prev_alt_q;
  logic [CntW-1:0]        fall_q, fall_d;
  logic [CntW-1:0]        rise_q, rise_d;

  logic signed [CmpW-1:0] now_s, old_s, jump_s, old_lo, old_hi;
  logic [CntW:0]          fall_sum, rise_sum;
  logic [CntW-1:0]        fall_new, rise_new;
  logic [CntW-1:0]        limit_ext;

  assign now_s  = CmpW'(altitude_i);
  assign old_s  = CmpW'(prev_alt_q);
  assign jump_s = signed'(CmpW'(alt_jump_i));
  assign old_lo = old_s - jump_s;
  assign old_hi = old_s + jump_s;
  assign limit_ext = CntW'(trend_limit_i);

  always_comb begin
    fall_sum = '0;
    if (now_s <= old_lo) begin
      fall_sum = {1'b0, fall_q} + JumpStep;
    end else if (now_s < old_s) begin
      fall_sum = {1'b0, fall_q} + SmallStep;
    end
    fall_new = fall_sum[CntW] ? CntMax : fall_sum[CntW-1:0];

    rise_sum = '0;
    if (now_s >= old_hi) begin
      rise_sum = {1'b0, rise_q} + JumpStep;
    end else if (now_s > old_s) begin
      rise_sum = {1'b0, rise_q} + SmallStep;
    end
    rise_new = rise_sum[CntW] ? CntMax : rise_sum[CntW-1:0];
  end

  // Falling has priority; only the winning counter clears.
  always_comb begin
    fall_d  = fall_new;
    rise_d  = rise_new;
    trend_o = TREND_STATIONARY;
    if (fall_new >= limit_ext) begin
      trend_o = TREND_FALLING;
      fall_d  = '0;
    end else if (rise_new >= limit_ext) begin
      trend_o = TREND_RISING;
      rise_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_alt_q <= '0;
      fall_q     <= '0;
      rise_q     <= '0;
    end else if (step_i) begin
      prev_alt_q <= altitude_i;
      fall_q     <= fall_d;
      rise_q     <= rise_d;
    end
  end

  `FPD_ASSERT(a_fall_clears, step_i && trend_o == TREND_FALLING |=> fall_q == '0, "fall counter not cleared")
  `FPD_ASSERT(a_rise_clears, step_i && trend_o == TREND_RISING |=> rise_q == '0, "rise counter not cleared")
  `FPD_ASSERT(a_prev_alt, step_i |=> prev_alt_q == $past(altitude_i), "previous altitude not captured")
  `FPD_ASSERT(a_idle_hold, !step_i |=> $stable(fall_q) && $stable(rise_q) && $stable(prev_alt_q), "trend state moved without a sample")

endmodule

`default_nettype wire

/* src/fpd_accel_class.sv */
`default_nettype none

module fpd_accel_class (
  input  wire logic signed [fpd_pkg::AccW-1:0] accel_i,
  input  wire logic [fpd_pkg::GravW-1:0]       gravity_i,
  input  wire logic [fpd_pkg::BandW-1:0]       band_i,
  output fpd_pkg::accel_class_e                class_o
);
  import fpd_pkg::*;

  logic signed [CmpW-1:0] a_s, b_s, g_s, neg_b, neg_g_lo, neg_g_hi;

  assign a_s      = CmpW'(accel_i);
  assign b_s      = signed'(CmpW'(band_i));
  assign g_s      = signed'(CmpW'(gravity_i));
  assign neg_b    = -b_s;
  assign neg_g_lo = -g_s - b_s;
  assign neg_g_hi = -g_s + b_s;

  // Bands tested in priority order; earlier band wins where they overlap.
  always_comb begin
    if (a_s >= neg_b && a_s <= b_s) begin
      class_o = ACC_NEAR_ZERO;
    end else if (a_s >= neg_g_lo && a_s <= neg_g_hi) begin
      class_o = ACC_NEAR_G;
    end else if (a_s > b_s) begin
      class_o = ACC_HIGH_POS;
    end else if (a_s <= neg_b && a_s >= neg_g_hi) begin
      class_o = ACC_LOW_NEG;
    end else begin
      class_o = ACC_HIGH_NEG;
    end
  end

endmodule

`default_nettype wire

/* src/flight_phase_detector.sv */
`default_nettype none

// Flight phase detector. Each input transfer carries one altitude sample (cm), one
// low-passed vertical acceleration (mm/s^2), the parachute-deployed bit and the
// attitude-stable bit; each produces exactly one result transfer with the altitude
// trend pulse, the acceleration band and the decoded flight state. The block takes
// one sample per clock cycle sustained while results are taken. A sample sits
// in the input register; the trend counters, band compares and state decode are
// combinational logic behind it, and their result is registered in the output
// register with result valid high when the sample moves on. A new sample is taken
// while a result still waits downstream; with both registers full and the result
// not taken, the input stalls. The one-sample-per-cycle rate is set by the trend
// counter update, which closes on itself (previous altitude, rise and fall
// counters). Configuration writes are always ready and take effect on the next
// cycle; write them only while no sample is in flight. Trend counters and the
// previous altitude reset to zero, so the first sample is compared against zero.

`include "flight_phase_detector_macros.svh"

module flight_phase_detector (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  fpd_cfg_if.sink    cfg_i,
  fpd_in_if.sink     in_i,
  fpd_out_if.source  out_o
);
  import fpd_pkg::*;

  cfg_t cfg;

  // Input stage.
  logic                   s1_v_q;
  logic signed [AltW-1:0] s1_alt_q;
  logic signed [AccW-1:0] s1_acc_q;
  logic                   s1_chute_q;
  logic                   s1_stab_q;

  // Result stage.
  logic          out_v_q;
  trend_e        out_trend_q;
  accel_class_e  out_cls_q;
  flight_state_e out_state_q;

  logic          adv;        // input stage moves into the result register
  logic          in_xfer;
  trend_e        trend;
  accel_class_e  cls;
  flight_state_e state;

  assign adv         = s1_v_q && (!out_v_q || out_o.ready);
  assign in_i.ready  = !s1_v_q || adv;
  assign in_xfer     = in_i.valid && in_i.ready;

  fpd_cfg_regs u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  // Counter state only advances when the sample leaves the input stage.
  fpd_trend u_trend (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (adv),
    .altitude_i    (s1_alt_q),
    .alt_jump_i    (cfg.alt_jump_cm),
    .trend_limit_i (cfg.trend_limit),
    .trend_o       (trend)
  );

  fpd_accel_class u_accel (
    .accel_i   (s1_acc_q),
    .gravity_i (cfg.gravity_mms2),
    .band_i    (cfg.accel_band_mms2),
    .class_o   (cls)
  );

  assign state = decode_state(trend, cls, s1_chute_q, s1_stab_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_v_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_alt_q   <= in_i.altitude_cm;
      s1_acc_q   <= in_i.vertical_accel;
      s1_chute_q <= in_i.parachute_deployed;
      s1_stab_q  <= in_i.stable;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (adv) begin
      out_v_q <= 1'b1;
    end else if (out_o.ready) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_trend_q <= trend;
      out_cls_q   <= cls;
      out_state_q <= state;
    end
  end

  assign out_o.valid          = out_v_q;
  assign out_o.altitude_trend = out_trend_q;
  assign out_o.accel_class    = out_cls_q;
  assign out_o.flight_state   = out_state_q;

  // A stalled input stage keeps its sample.
  `FPD_ASSERT(a_s1_hold, s1_v_q && !adv |=> s1_v_q && $stable(s1_alt_q) && $stable(s1_acc_q), "input stage lost its sample")
  // Every advance shows up as a result.
  `FPD_ASSERT(a_adv_out, adv |=> out_v_q, "advanced sample missing at output")
  // Pre-launch states only come from a quiet, stationary sample.
  `FPD_ASSERT(a_prelaunch, out_v_q && (out_state_q == FS_STABILIZE || out_state_q == FS_READY) |-> out_trend_q == TREND_STATIONARY && out_cls_q == ACC_NEAR_ZERO, "pre-launch state decoded wrongly")
  // A result not taken stays put.
  `FPD_ASSERT(a_out_hold, out_v_q && !out_o.ready |=> out_v_q && $stable(out_state_q), "result dropped while stalled")

endmodule

`default_nettype wire

/* tb/flight_phase_detector_tb.sv */
`timescale 1ns / 1ps

module flight_phase_detector_tb;
  import fpd_pkg::*;

  // Index with no register behind it; a write there must change nothing.
  localparam logic [CfgIdxW-1:0] CfgNoReg = 8'd4;

  localparam longint AltMaxV = 8388607;
  localparam longint AltMinV = -8388608;

  // One sample as offered on the input channel.
  typedef struct packed {
    logic signed [AltW-1:0] alt;
    logic signed [AccW-1:0] acc;
    logic                   chute;
    logic                   stab;
  } fpd_sample_t;

  // One result as expected on the output channel.
  typedef struct packed {
    trend_e        trend;
    accel_class_e  cls;
    flight_state_e phase;
  } phase_result_t;

  // Directed table row. Rows with typed set carry a hand-written result.
  typedef struct {
    int            alt;
    int            acc;
    bit            chute;
    bit            stab;
    bit            typed;
    trend_e        tr;
    accel_class_e  ac;
    flight_state_e st;
  } dir_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  fpd_cfg_if cfg_bus ();
  fpd_in_if  smp_bus ();
  fpd_out_if res_bus ();

  flight_phase_detector dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_bus),
    .in_i   (smp_bus),
    .out_o  (res_bus)
  );

  // 12 ns period.
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor: shadow copy of the registers and of the trend state.
  // ---------------------------------------------------------------------------
  int unsigned jump_cm     = AltJumpRst;
  int          trend_limit = SampLimitRst;
  int unsigned grav        = GravityRst;
  int unsigned band        = AccelBandRst;

  logic signed [AltW-1:0] last_alt    = '0;
  int                     descent_cnt = 0;
  int                     climb_cnt   = 0;

  phase_result_t expected_q[$];
  int            err_count    = 0;
  int            results_seen = 0;
  int            gap_pct      = 0;   // chance (%) of an idle burst, both sides
  longint        cur_alt;            // altitude walk of the random part

  // Saturating trend counter step.
  function automatic int bump(int c, int k);
    return (c + k > int'(CntMax)) ? int'(CntMax) : c + k;
  endfunction

  // Work out the result of one accepted sample and advance the shadow state.
  function automatic phase_result_t predict_phase(fpd_sample_t s);
    longint        now_v, old_v, acc_v, jmp, b, g;
    phase_result_t r;
    now_v = longint'($signed(s.alt));
    old_v = longint'($signed(last_alt));
    acc_v = longint'($signed(s.acc));
    jmp   = jump_cm;
    b     = band;
    g     = grav;

    // Counters move only in their own direction, otherwise clear.
    if (now_v <= old_v - jmp)    descent_cnt = bump(descent_cnt, JumpStep);
    else if (now_v < old_v)      descent_cnt = bump(descent_cnt, SmallStep);
    else                         descent_cnt = 0;
    if (now_v >= old_v + jmp)    climb_cnt = bump(climb_cnt, JumpStep);
    else if (now_v > old_v)      climb_cnt = bump(climb_cnt, SmallStep);
    else                         climb_cnt = 0;

    // Falling has priority; only the winning counter clears.
    if (descent_cnt >= trend_limit) begin
      r.trend = TREND_FALLING;
      descent_cnt = 0;
    end else if (climb_cnt >= trend_limit) begin
      r.trend = TREND_RISING;
      climb_cnt = 0;
    end else begin
      r.trend = TREND_STATIONARY;
    end
    last_alt = s.alt;

    // Bands are tried in order, so overlaps resolve to the earlier one.
    if (acc_v >= -b && acc_v <= b)               r.cls = ACC_NEAR_ZERO;
    else if (acc_v >= -g - b && acc_v <= -g + b) r.cls = ACC_NEAR_G;
    else if (acc_v > b)                          r.cls = ACC_HIGH_POS;
    else if (acc_v <= -b && acc_v >= -g + b)     r.cls = ACC_LOW_NEG;
    else                                         r.cls = ACC_HIGH_NEG;

    r.phase = FS_UNKNOWN;
    if (!s.chute && r.trend == TREND_STATIONARY && r.cls == ACC_NEAR_ZERO) begin
      r.phase = s.stab ? FS_READY : FS_STABILIZE;
    end else if (s.stab && !s.chute) begin
      case (r.trend)
        TREND_RISING: begin
          if (r.cls == ACC_HIGH_POS) r.phase = FS_BOOST;
          else if (r.cls == ACC_NEAR_G || r.cls == ACC_LOW_NEG) r.phase = FS_COAST;
        end
        TREND_FALLING: begin
          if (r.cls == ACC_NEAR_G) r.phase = FS_FALL;
        end
        default: ;
      endcase
    end else if (s.stab) begin
      // Under canopy.
      if (r.trend == TREND_FALLING && r.cls == ACC_LOW_NEG)        r.phase = FS_CHUTE_SLOWING;
      else if (r.trend == TREND_FALLING && r.cls == ACC_NEAR_ZERO) r.phase = FS_CHUTE_TERMINAL;
      else if (r.trend == TREND_STATIONARY && r.cls == ACC_NEAR_ZERO) r.phase = FS_LANDED;
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Mismatch reporting and result checking.
  // ---------------------------------------------------------------------------
  task automatic flag_error(input string what);
    if (err_count < 100) $display("%0t ns: MISMATCH %s", $time, what);
    err_count++;
  endtask

  // Every result transfer is matched against the oldest outstanding prediction.
  always @(posedge clk_i) begin : result_check
    phase_result_t want;
    if (rst_ni && res_bus.valid && res_bus.ready) begin
      results_seen++;
      if (expected_q.size() == 0) begin
        flag_error("result transfer with nothing outstanding");
      end else begin
        want = expected_q.pop_front();
        if (res_bus.altitude_trend !== want.trend)
          flag_error($sformatf("result %0d trend %0d, want %0d",
                               results_seen, res_bus.altitude_trend, want.trend));
        if (res_bus.accel_class !== want.cls)
          flag_error($sformatf("result %0d accel class %0d, want %0d",
                               results_seen, res_bus.accel_class, want.cls));
        if (res_bus.flight_state !== want.phase)
          flag_error($sformatf("result %0d flight state %0d, want %0d",
                               results_seen, res_bus.flight_state, want.phase));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result side: random ready bursts, plus one long hold-off so the block
  // backs up and stalls its input while samples keep coming.
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    bit          long_hold_done;
    int unsigned pause;
    long_hold_done = 1'b0;
    res_bus.ready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      if (!long_hold_done && results_seen >= 500) begin
        long_hold_done = 1'b1;
        res_bus.ready <= 1'b0;
        repeat (400) @(posedge clk_i);
      end else if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
        res_bus.ready <= 1'b0;
        pause = $urandom_range(1, 15);
        repeat (pause) @(posedge clk_i);
      end
      res_bus.ready <= 1'b1;
      @(posedge clk_i);
    end
  end

  // ---------------------------------------------------------------------------
  // Input and configuration drivers.
  // ---------------------------------------------------------------------------

  // Offer one sample, maybe after an idle burst; predict once it transfers.
  // valid is left high so back-to-back samples never toggle it within a step.
  task automatic send_sample(input fpd_sample_t s, input bit typed,
                             input phase_result_t typed_res);
    int unsigned   gap;
    phase_result_t res;
    if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      smp_bus.valid <= 1'b0;
      gap = $urandom_range(1, 15);
      repeat (gap) @(posedge clk_i);
    end
    smp_bus.valid              <= 1'b1;
    smp_bus.altitude_cm        <= s.alt;
    smp_bus.vertical_accel     <= s.acc;
    smp_bus.parachute_deployed <= s.chute;
    smp_bus.stable             <= s.stab;
    @(posedge clk_i);
    while (smp_bus.ready !== 1'b1) @(posedge clk_i);
    res = predict_phase(s);
    expected_q.push_back(typed ? typed_res : res);
  endtask

  // Drop valid and let every outstanding result come back.
  task automatic wait_drained();
    smp_bus.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  // One register write; the shadow copy follows the transfer. valid stays high.
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] wdata);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= wdata;
    @(posedge clk_i);
    while (cfg_bus.ready !== 1'b1) @(posedge clk_i);
    case (idx)
      CfgAltJump:   jump_cm     = wdata[JumpW-1:0];
      CfgSampLimit: trend_limit = wdata[LimitW-1:0];
      CfgGravity:   grav        = wdata[GravW-1:0];
      CfgAccelBand: band        = wdata[BandW-1:0];
      default: ;
    endcase
  endtask

  // New setting for all four registers, only once the block has gone idle.
  task automatic apply_settings(input int unsigned jmp, input logic [CfgDataW-1:0] lim_word,
                                input int unsigned gv, input int unsigned bd);
    wait_drained();
    write_reg(CfgAltJump, CfgDataW'(jmp));
    write_reg(CfgSampLimit, lim_word);
    write_reg(CfgGravity, CfgDataW'(gv));
    write_reg(CfgAccelBand, CfgDataW'(bd));
    cfg_bus.valid <= 1'b0;
  endtask

  // Acceleration aimed mostly at band edges of the current setting.
  function automatic logic signed [AccW-1:0] pick_accel();
    longint a, b, g;
    b = band;
    g = grav;
    case ($urandom_range(0, 9))
      0: a = b;
      1: a = -b;
      2: a = b + 1;
      3: a = -b - 1;
      4: a = -g - b;
      5: a = -g + b;
      6: a = -g - b - 1;
      7: a = -g + b + 1;
      8: a = longint'($signed(AccW'($urandom)));
      default: a = longint'($urandom_range(0, 2 * (g + b) + 20)) - (g + b + 10);
    endcase
    return AccW'(a);
  endfunction

  // Random part: mostly climbs, drops and level runs with steps around the
  // jump threshold, so the trend counters actually reach the limit; one pick
  // in ten is a single sample of raw noise over the full field widths.
  task automatic run_random(input int n_items);
    int          done, k, len, dir;
    longint      step, nxt;
    fpd_sample_t s;
    logic        chute_run, stab_run;
    done = 0;
    cur_alt = longint'($signed(last_alt));
    while (done < n_items) begin
      if ($urandom_range(0, 9) == 0) begin
        s.alt   = AltW'($urandom);
        s.acc   = AccW'($urandom);
        s.chute = $urandom_range(0, 1);
        s.stab  = $urandom_range(0, 1);
        cur_alt = longint'($signed(s.alt));
        send_sample(s, 1'b0, '0);
        done++;
      end else begin
        dir       = int'($urandom_range(0, 2)) - 1;
        len       = $urandom_range(1, trend_limit / 2 + 20);
        chute_run = $urandom_range(0, 1);
        stab_run  = ($urandom_range(0, 4) != 0);
        for (k = 0; k < len && done < n_items; k++) begin
          case ($urandom_range(0, 5))
            0:       step = jump_cm;
            1:       step = (jump_cm > 0) ? jump_cm - 1 : 0;
            2:       step = $urandom_range(0, jump_cm);
            3, 4:    step = longint'(jump_cm) + $urandom_range(0, 1000);
            default: step = $urandom_range(1, 3);
          endcase
          nxt = cur_alt + dir * step;
          if (nxt > AltMaxV || nxt < AltMinV) begin
            dir = -dir;
            nxt = cur_alt + dir * step;
          end
          cur_alt = nxt;
          s.alt   = AltW'(cur_alt);
          s.acc   = pick_accel();
          s.chute = ($urandom_range(0, 15) == 0) ? !chute_run : chute_run;
          s.stab  = ($urandom_range(0, 15) == 0) ? !stab_run : stab_run;
          send_sample(s, 1'b0, '0);
          done++;
        end
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus sequence.
  // ---------------------------------------------------------------------------
  dir_row_t directed[24];

  initial begin : stimulus
    fpd_sample_t   s;
    phase_result_t want;
    int            i;

    rst_ni                     = 1'b0;
    cfg_bus.valid              = 1'b0;
    cfg_bus.index              = CfgAltJump;
    cfg_bus.data               = '0;
    smp_bus.valid              = 1'b0;
    smp_bus.altitude_cm        = '0;
    smp_bus.vertical_accel     = '0;
    smp_bus.parachute_deployed = 1'b0;
    smp_bus.stable             = 1'b0;

    // Directed part, reset register values (jump 100, limit 10, g 9807,
    // band 1000). Hand-written results only where they are obvious.
    directed = '{
      // first sample after reset compares against zero: level, near zero
      '{0, 0, 1'b0, 1'b1, 1'b1, TREND_STATIONARY, ACC_NEAR_ZERO, FS_READY},
      '{0, 0, 1'b0, 1'b0, 1'b1, TREND_STATIONARY, ACC_NEAR_ZERO, FS_STABILIZE},
      // field extremes
      '{8388607, 8388607, 1'b0, 1'b1, 1'b1,
        TREND_STATIONARY, ACC_HIGH_POS, FS_UNKNOWN},
      '{-8388608, -8388608, 1'b1, 1'b1, 1'b1,
        TREND_STATIONARY, ACC_HIGH_NEG, FS_UNKNOWN},
      // band edges, including where near -g and low negative meet
      '{0, 1000,   1'b0, 1'b1, 1'b0, TREND_STATIONARY, ACC_NEAR_ZERO, FS_UNKNOWN},
      '{0, -1000,  1'b0, 1'b1, 1'b0, TREND_STATIONARY, ACC_NEAR_ZERO, FS_UNKNOWN},
      '{0, 1001,   1'b0, 1'b1, 1'b0, TREND_STATIONARY, ACC_NEAR_ZERO, FS_UNKNOWN},
      '{0, -1001,  1'b0, 1'b1, 1'b0, TREND_STATIONARY, ACC_NEAR_ZERO, FS_UNKNOWN},
      '{0, -8806,  1'b0, 1'b1, 1'b0, TREND_STATIONARY, ACC_NEAR_ZERO, FS_UNKNOWN},
      '{0, -8807,  1'b0, 1'b1, 1'b0, TREND_STATIONARY, ACC_NEAR_ZERO, FS_UNKNOWN},
      '{0, -10807, 1'b0, 1'b1, 1'b0, TREND_STATIONARY, ACC_NEAR_ZERO, FS_UNKNOWN},
      '{0, -10808, 1'b0, 1'b1, 1'b0, TREND_STATIONARY, ACC_NEAR_ZERO, FS_UNKNOWN},
      // climb: jump, just under jump, jump, jump -> rising pulse, boost
      '{100, 20000, 1'b0, 1'b1, 1'b0, TREND_STATIONARY, ACC_NEAR_ZERO, FS_UNKNOWN},
      '{199, 20000, 1'b0, 1'b1, 1'b0, TREND_STATIONARY, ACC_NEAR_ZERO, FS_UNKNOWN},
      '{299, 20000, 1'b0, 1'b1, 1'b0, TREND_STATIONARY, ACC_NEAR_ZERO, FS_UNKNOWN},
      '{399, 20000, 1'b0, 1'b1, 1'b0, TREND_STATIONARY, ACC_NEAR_ZERO, FS_UNKNOWN},
      // free fall near -g -> falling pulse, fall
      '{299, -9807, 1'b0, 1'b1, 1'b0, TREND_STATIONARY, ACC_NEAR_ZERO, FS_UNKNOWN},
      '{199, -9807, 1'b0, 1'b1, 1'b0, TREND_STATIONARY, ACC_NEAR_ZERO, FS_UNKNOWN},
      '{99,  -9807, 1'b0, 1'b1, 1'b0, TREND_STATIONARY, ACC_NEAR_ZERO, FS_UNKNOWN},
      '{-1,  -9807, 1'b0, 1'b1, 1'b0, TREND_STATIONARY, ACC_NEAR_ZERO, FS_UNKNOWN},
      // under canopy at terminal speed
      '{-201, 0, 1'b1, 1'b1, 1'b0, TREND_STATIONARY, ACC_NEAR_ZERO, FS_UNKNOWN},
      '{-401, 0, 1'b1, 1'b1, 1'b0, TREND_STATIONARY, ACC_NEAR_ZERO, FS_UNKNOWN},
      '{-601, 0, 1'b1, 1'b1, 1'b0, TREND_STATIONARY, ACC_NEAR_ZERO, FS_UNKNOWN},
      '{-801, 0, 1'b1, 1'b1, 1'b0, TREND_STATIONARY, ACC_NEAR_ZERO, FS_UNKNOWN}
    };

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    gap_pct = 20;
    for (i = 0; i < 24; i++) begin
      s.alt   = AltW'(directed[i].alt);
      s.acc   = AccW'(directed[i].acc);
      s.chute = directed[i].chute;
      s.stab  = directed[i].stab;
      want    = '{directed[i].tr, directed[i].ac, directed[i].st};
      send_sample(s, directed[i].typed, want);
    end

    // Write to an unused index first; nothing may change.
    wait_drained();
    write_reg(CfgNoReg, '1);
    cfg_bus.valid <= 1'b0;

    // Reset values written back explicitly.
    apply_settings(100, CfgDataW'(10), 9807, 1000);
    gap_pct = 30;
    run_random(350);

    // Low extremes: any move is a jump, limit one, bands collapse onto zero.
    // The long result hold-off lands in this stretch.
    apply_settings(0, CfgDataW'(1), 0, 0);
    gap_pct = 50;
    run_random(300);

    // Top of the stated ranges; sender stops midway until all results are back.
    apply_settings(100000, CfgDataW'(255), 50000, 10000);
    gap_pct = 10;
    run_random(150);
    wait_drained();
    run_random(200);

    // Full-width registers and a zero limit: every sample reports falling.
    apply_settings(131071, CfgDataW'(0), 65535, 16383);
    gap_pct = 0;
    run_random(250);

    // Random full-width setting, junk above the 8-bit limit field.
    apply_settings($urandom_range(0, 131071),
                   {9'($urandom), 8'($urandom_range(0, 255))},
                   $urandom_range(0, 65535), $urandom_range(0, 16383));
    gap_pct = 30;
    run_random(350);

    // Realistic setting with a short limit, run at full rate to the end.
    apply_settings($urandom_range(1, 300), CfgDataW'($urandom_range(2, 12)),
                   $urandom_range(9000, 10500), $urandom_range(200, 2000));
    gap_pct = 0;
    run_random(400);

    wait_drained();
    if (err_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Hard stop far beyond the slowest legal run.
  initial begin : watchdog
    #10_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
